// ===== rtl/igc_pkg.sv =====
// Shared types and constants of the IMU gesture classifier.
// Holds the register index codes, the beat kinds, the register file struct and the result
// flags struct. Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package igc_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned RotSumW   = 40;
  localparam int unsigned YAverageW = 25;

  // Register index codes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgAccelXOffset = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAccelYOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGyroXOffset  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLateralLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgVertLimit    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRotLimit     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgAvgWeight    = 3'd6;

  // Kinds of input beat.
  localparam logic KindTick = 1'b0;
  localparam logic KindPoll = 1'b1;

  // Register values after reset.
  localparam logic [15:0] LateralLimitRst = 16'd200;
  localparam logic [15:0] VertLimitRst    = 16'd250;
  localparam logic [31:0] RotLimitRst     = 32'd125000;
  localparam logic [8:0]  AvgWeightRst    = 9'd26;

  // Full weight of the new sample in the running average (1/256 units).
  localparam logic [8:0]  AvgWeightMax    = 9'd256;

  typedef struct packed {
    logic signed [15:0] accel_x_offset;
    logic signed [15:0] accel_y_offset;
    logic signed [23:0] gyro_x_offset;
    logic        [15:0] lateral_limit;
    logic        [15:0] vertical_limit;
    logic        [31:0] rotation_limit;
    logic        [8:0]  average_weight;
  } cfg_t;

  typedef struct packed {
    logic move_right;
    logic move_left;
    logic move_up;
    logic move_down;
    logic hit_pressed;
    logic jump_flag;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/igc_datapath.sv =====
// Combinational datapath of the IMU gesture classifier.
// Computes the saturated rotation sum after a tick, the gesture flags of a poll and the
// next running y average. Depends on igc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module igc_datapath (
  input  igc_pkg::cfg_t       cfg_i,
  input  logic signed [23:0]  gyro_x_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic                button_level_i,
  input  logic signed [39:0]  rot_sum_i,
  input  logic signed [24:0]  y_avg_i,
  output logic signed [39:0]  rot_tick_o,
  output logic signed [24:0]  y_avg_o,
  output igc_pkg::flags_t     flags_o
);
  import igc_pkg::*;

  localparam logic signed [39:0] RotMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] RotMin = {1'b1, {39{1'b0}}};

  logic signed [24:0] gyro_corr;
  logic signed [40:0] rot_wide;
  logic signed [17:0] dx;
  logic signed [17:0] lat;
  logic signed [16:0] ay_corr;
  logic signed [26:0] dy;
  logic signed [26:0] vert;
  logic        [8:0]  weight;
  logic signed [9:0]  weight_s;
  logic signed [25:0] avg_err;
  logic signed [35:0] avg_prod;
  logic signed [36:0] avg_acc;

  // Gyro tick: corrected rate into a saturating sum.
  assign gyro_corr = $signed({gyro_x_i[23], gyro_x_i})
                   - $signed({cfg_i.gyro_x_offset[23], cfg_i.gyro_x_offset});
  assign rot_wide  = $signed({rot_sum_i[39], rot_sum_i})
                   + $signed({{16{gyro_corr[24]}}, gyro_corr});

  always_comb begin
    if (rot_wide[40] != rot_wide[39]) begin
      rot_tick_o = rot_wide[40] ? RotMin : RotMax;
    end else begin
      rot_tick_o = rot_wide[39:0];
    end
  end

  // Lateral tilt against the signed limit window.
  assign dx  = $signed({{2{accel_x_i[15]}}, accel_x_i})
             - $signed({{2{cfg_i.accel_x_offset[15]}}, cfg_i.accel_x_offset});
  assign lat = $signed({2'b00, cfg_i.lateral_limit});

  // Vertical deviation from the average, all in 1/256 counts.
  assign ay_corr = $signed({accel_y_i[15], accel_y_i})
                 - $signed({cfg_i.accel_y_offset[15], cfg_i.accel_y_offset});
  assign dy      = $signed({{2{ay_corr[16]}}, ay_corr, 8'h00})
                 - $signed({{2{y_avg_i[24]}}, y_avg_i});
  assign vert    = $signed({3'b000, cfg_i.vertical_limit, 8'h00});

  // The weighted sum is rewritten as avg * 256 + w * (y * 256 - avg), which needs
  // only one multiplier. Adding half an LSB and shifting rounds ties upward.
  assign weight   = (cfg_i.average_weight > AvgWeightMax) ? AvgWeightMax
                                                          : cfg_i.average_weight;
  assign weight_s = $signed({1'b0, weight});
  assign avg_err  = $signed({{2{accel_y_i[15]}}, accel_y_i, 8'h00})
                  - $signed({y_avg_i[24], y_avg_i});
  assign avg_prod = weight_s * avg_err;
  assign avg_acc  = $signed({{4{y_avg_i[24]}}, y_avg_i, 8'h00})
                  + $signed({avg_prod[35], avg_prod})
                  + 37'sd128;
  assign y_avg_o  = avg_acc[32:8];

  always_comb begin
    flags_o             = '0;
    flags_o.move_left   = (dx > lat);
    flags_o.move_right  = (dx < -lat);
    flags_o.move_up     = (dy > vert);
    flags_o.move_down   = (dy < -vert);
    flags_o.hit_pressed = ~button_level_i;
    flags_o.jump_flag   = ~rot_sum_i[39] && (rot_sum_i[38:0] > {7'd0, cfg_i.rotation_limit});
  end

endmodule

`default_nettype wire

// ===== rtl/imu_gesture_classifier.sv =====
// Top level of the IMU gesture classifier: configuration registers, input stage,
// gesture state and result register. Depends on igc_pkg and igc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The classifier takes one input beat per clock cycle while in_stall_o is low. A
// beat of kind 0 is a gyro tick: its offset-corrected x rate is added to a
// saturating 40-bit rotation sum and it produces no result. A beat of kind 1 is an
// action poll and produces exactly one result beat, carrying the left, right, up,
// down, hit and jump flags; the result is valid on the output once the poll has
// passed the input and result registers. The poll also clears the rotation sum
// and moves the running y average toward the new sample. Every input beat is first
// captured in an input register, and the update is done by combinational adds,
// compares and one 9 by 26 bit multiply on the way to the result register. A tick
// never waits in the input register; a poll waits there only while the result
// register holds a beat that the downstream side stalls. Registers are written
// through cfg_we_i, cfg_index_i and cfg_data_i; the user must write them only
// while the block is idle, which the block itself does not enforce. Indexes
// without a register are ignored. There is no clearing pass after reset.
module imu_gesture_classifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration port.
  input  logic                             cfg_we_i,
  input  logic [igc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [igc_pkg::CfgDataW-1:0]     cfg_data_i,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic signed [23:0]               gyro_x_i,
  input  logic signed [15:0]               accel_x_i,
  input  logic signed [15:0]               accel_y_i,
  input  logic                             button_level_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             move_right_o,
  output logic                             move_left_o,
  output logic                             move_up_o,
  output logic                             move_down_o,
  output logic                             hit_pressed_o,
  output logic                             jump_flag_o
);
  import igc_pkg::*;

  cfg_t cfg_q;

  // Input register.
  logic               s1_valid_q;
  logic               s1_kind_q;
  logic signed [23:0] s1_gyro_x_q;
  logic signed [15:0] s1_accel_x_q;
  logic signed [15:0] s1_accel_y_q;
  logic               s1_button_q;

  // Gesture state.
  logic signed [RotSumW-1:0]   rot_sum_q;
  logic signed [YAverageW-1:0] y_avg_q;

  // Result register.
  logic   out_valid_q;
  flags_t out_flags_q;

  logic signed [RotSumW-1:0]   rot_tick;
  logic signed [YAverageW-1:0] y_avg_d;
  flags_t                      flags_d;

  logic out_free;
  logic s1_advance;
  logic s1_is_poll;
  logic in_accept;

  // The result register can take a new beat when it is empty or is being drained
  // in this cycle. Ticks leave the input register regardless.
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_is_poll = (s1_kind_q != KindTick);
  assign s1_advance = s1_valid_q & (~s1_is_poll | out_free);
  assign in_stall_o = s1_valid_q & ~s1_advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_x_offset <= '0;
      cfg_q.accel_y_offset <= '0;
      cfg_q.gyro_x_offset  <= '0;
      cfg_q.lateral_limit  <= LateralLimitRst;
      cfg_q.vertical_limit <= VertLimitRst;
      cfg_q.rotation_limit <= RotLimitRst;
      cfg_q.average_weight <= AvgWeightRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAccelXOffset: cfg_q.accel_x_offset <= cfg_data_i[15:0];
        CfgAccelYOffset: cfg_q.accel_y_offset <= cfg_data_i[15:0];
        CfgGyroXOffset:  cfg_q.gyro_x_offset  <= cfg_data_i[23:0];
        CfgLateralLimit: cfg_q.lateral_limit  <= cfg_data_i[15:0];
        CfgVertLimit:    cfg_q.vertical_limit <= cfg_data_i[15:0];
        CfgRotLimit:     cfg_q.rotation_limit <= cfg_data_i[31:0];
        CfgAvgWeight:    cfg_q.average_weight <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q    <= kind_i;
      s1_gyro_x_q  <= gyro_x_i;
      s1_accel_x_q <= accel_x_i;
      s1_accel_y_q <= accel_y_i;
      s1_button_q  <= button_level_i;
    end
  end

  igc_datapath u_datapath (
    .cfg_i          (cfg_q),
    .gyro_x_i       (s1_gyro_x_q),
    .accel_x_i      (s1_accel_x_q),
    .accel_y_i      (s1_accel_y_q),
    .button_level_i (s1_button_q),
    .rot_sum_i      (rot_sum_q),
    .y_avg_i        (y_avg_q),
    .rot_tick_o     (rot_tick),
    .y_avg_o        (y_avg_d),
    .flags_o        (flags_d)
  );

  // Gesture state: a tick accumulates, a poll clears the sum and updates the average.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_sum_q <= '0;
      y_avg_q   <= '0;
    end else if (s1_advance) begin
      if (s1_is_poll) begin
        rot_sum_q <= '0;
        y_avg_q   <= y_avg_d;
      end else begin
        rot_sum_q <= rot_tick;
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance && s1_is_poll) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_is_poll) begin
      out_flags_q <= flags_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign move_right_o  = out_flags_q.move_right;
  assign move_left_o   = out_flags_q.move_left;
  assign move_up_o     = out_flags_q.move_up;
  assign move_down_o   = out_flags_q.move_down;
  assign hit_pressed_o = out_flags_q.hit_pressed;
  assign jump_flag_o   = out_flags_q.jump_flag;

endmodule

`default_nettype wire
